### src/rse_pkg.sv
package rse_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Field widths
  localparam int OP_W       = 3;
  localparam int NUM_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int DEPTH_W    = 9;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  // Divider
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Token op codes
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ERR_NONE = 2'd0;
  localparam logic [STATUS_W-1:0] ERR_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] ERR_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ERR_DIV0 = 2'd3;

  localparam logic signed [NUM_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [NUM_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_MULT,
    S_DIVIDE,
    S_WRITE,
    S_REPORT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic                load;
    logic                push;
    logic                err_we;
    logic [STATUS_W-1:0] err_code;
    logic                rd;
    logic                addsub;
    logic                mul_start;
    logic                mul_take;
    logic                div_start;
    logic                div_take;
    logic                wb;
    logic                report;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            err_held;
    logic            full;
    logic            few;
    logic            top_zero;
    logic            div_done;
    logic            out_free;
  } sts_t;

  // Clamp a wide signed value to the Q16.16 range
  function automatic logic signed [NUM_W-1:0] sat_q(input logic signed [63:0] v);
    logic signed [NUM_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = Q_MAX;
    end else if (v < -64'sd2147483648) begin
      r = Q_MIN;
    end else begin
      r = v[NUM_W-1:0];
    end
    return r;
  endfunction

endpackage

### src/rse_divider.sv
module rse_divider
  import rse_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] s,
  input  logic signed [NUM_W-1:0] t,
  output logic                    done,
  output logic signed [NUM_W-1:0] quo
);

  logic [DIV_CNT_W-1:0] count;
  logic [NUM_W-1:0]     rem;
  logic [NUM_W-1:0]     dq;
  logic [NUM_W-1:0]     tmag;
  logic                 neg;
  logic                 ovf;

  logic [NUM_W-1:0] smag_in;
  logic [NUM_W-1:0] tmag_in;
  logic [NUM_W:0]   trial;
  logic             ge;

  // Operand magnitudes; -2^31 maps to 2^31 unsigned
  assign smag_in = s[NUM_W-1] ? NUM_W'(-s) : NUM_W'(s);
  assign tmag_in = t[NUM_W-1] ? NUM_W'(-t) : NUM_W'(t);

  // Restoring step, one quotient bit per cycle
  assign trial = {rem, dq[NUM_W-1]};
  assign ge    = trial >= {1'b0, tmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= DIV_CNT_W'(DIV_STEPS);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  // Dividend is |s| << 16; quotient fits 32 bits unless |s| >= |t| << 16
  always_ff @(posedge clk) begin
    if (start) begin
      tmag <= tmag_in;
      neg  <= s[NUM_W-1] ^ t[NUM_W-1];
      ovf  <= {16'b0, smag_in} >= {tmag_in, 16'b0};
      rem  <= {16'b0, smag_in[31:16]};
      dq   <= {smag_in[15:0], 16'b0};
    end else if (count != '0) begin
      rem <= ge ? NUM_W'(trial - {1'b0, tmag}) : trial[NUM_W-1:0];
      dq  <= {dq[NUM_W-2:0], ge};
    end
  end

  assign done = (count == '0);

  // Sign and saturation
  always_comb begin
    if (ovf) begin
      quo = neg ? Q_MIN : Q_MAX;
    end else if (!neg) begin
      quo = (dq > 32'h7FFF_FFFF) ? Q_MAX : dq;
    end else begin
      quo = (dq > 32'h8000_0000) ? Q_MIN : NUM_W'(-dq);
    end
  end

endmodule

### src/rse_datapath.sv
module rse_datapath
  import rse_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [OP_W-1:0]     in_op,
  input  logic [NUM_W-1:0]    in_num,
  input  logic                in_last,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [NUM_W-1:0]    out_result,
  output logic [DEPTH_W-1:0]  out_depth,
  output logic                out_last
);

  logic [NUM_W-1:0] mem [STACK_DEPTH];

  logic [OP_W-1:0]         tok_op;
  logic [NUM_W-1:0]        tok_num;
  logic                    tok_last;
  logic [CNT_W-1:0]        cnt;
  logic [STATUS_W-1:0]     err;
  logic signed [NUM_W-1:0] top;
  logic signed [NUM_W-1:0] bottom;
  logic signed [NUM_W-1:0] rdata;
  logic signed [NUM_W-1:0] res;
  logic signed [63:0]      prod;

  logic [ADDR_W-1:0]       sub_idx;
  logic signed [NUM_W:0]   sum;
  logic signed [NUM_W-1:0] div_q;
  logic                    div_done;

  // Second-from-top entry
  assign sub_idx = ADDR_W'(cnt - CNT_W'(2));

  // Token latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tok_op   <= in_op;
      tok_num  <= in_num;
      tok_last <= in_last;
    end
  end

  // Stack memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[cnt[ADDR_W-1:0]] <= tok_num;
    end else if (cmd.wb) begin
      mem[sub_idx] <= res;
    end
    if (cmd.rd) begin
      rdata <= mem[sub_idx];
    end
  end

  // Cached top and bottom entries
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top <= tok_num;
      if (cnt == '0) begin
        bottom <= tok_num;
      end
    end else if (cmd.wb) begin
      top <= res;
      if (cnt == CNT_W'(2)) begin
        bottom <= res;
      end
    end
  end

  // Depth and sticky error
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      err <= ERR_NONE;
    end else begin
      if (cmd.report && tok_last) begin
        cnt <= '0;
        err <= ERR_NONE;
      end else begin
        if (cmd.push) begin
          cnt <= cnt + 1'b1;
        end else if (cmd.wb) begin
          cnt <= cnt - 1'b1;
        end
        if (cmd.err_we) begin
          err <= cmd.err_code;
        end
      end
    end
  end

  // Arithmetic
  assign sum = (tok_op == OP_SUB) ? {rdata[NUM_W-1], rdata} - {top[NUM_W-1], top}
                                  : {rdata[NUM_W-1], rdata} + {top[NUM_W-1], top};

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      prod <= rdata * top;
    end
    if (cmd.addsub) begin
      res <= sat_q(64'(sum));
    end else if (cmd.mul_take) begin
      res <= sat_q(prod >>> 16);
    end else if (cmd.div_take) begin
      res <= div_q;
    end
  end

  rse_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .s     (rdata),
    .t     (top),
    .done  (div_done),
    .quo   (div_q)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_status <= err;
      out_depth  <= DEPTH_W'(cnt);
      out_last   <= tok_last;
      if (cnt == '0) begin
        out_result <= '0;
      end else begin
        out_result <= tok_last ? bottom : top;
      end
    end
  end

  // Status to controller
  always_comb begin
    sts.op       = tok_op;
    sts.err_held = (err != ERR_NONE);
    sts.full     = (cnt == CNT_W'(STACK_DEPTH));
    sts.few      = (cnt < CNT_W'(2));
    sts.top_zero = (top == '0);
    sts.div_done = div_done;
    sts.out_free = !out_valid || out_ready;
  end

endmodule

### src/rse_ctrl.sv
module rse_ctrl
  import rse_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.err_held || sts.op == OP_PUSH || sts.op > OP_DIV || sts.few ||
            (sts.op == OP_DIV && sts.top_zero)) begin
          state_next = S_REPORT;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        case (sts.op)
          OP_MUL:  state_next = S_MULT;
          OP_DIV:  state_next = S_DIVIDE;
          default: state_next = S_WRITE;
        endcase
      end
      S_MULT: state_next = S_WRITE;
      S_DIVIDE: begin
        if (sts.div_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: state_next = S_REPORT;
      S_REPORT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: begin
        if (!sts.err_held) begin
          if (sts.op == OP_PUSH) begin
            if (sts.full) begin
              cmd.err_we   = 1'b1;
              cmd.err_code = ERR_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (sts.op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV}) begin
            if (sts.few) begin
              cmd.err_we   = 1'b1;
              cmd.err_code = ERR_FEW;
            end else if (sts.op == OP_DIV && sts.top_zero) begin
              cmd.err_we   = 1'b1;
              cmd.err_code = ERR_DIV0;
            end else begin
              cmd.rd = 1'b1;
            end
          end
        end
      end
      S_FETCH: begin
        case (sts.op)
          OP_MUL:  cmd.mul_start = 1'b1;
          OP_DIV:  cmd.div_start = 1'b1;
          default: cmd.addsub    = 1'b1;
        endcase
      end
      S_MULT:   cmd.mul_take = 1'b1;
      S_DIVIDE: cmd.div_take = sts.div_done;
      S_WRITE:  cmd.wb       = 1'b1;
      S_REPORT: cmd.report   = sts.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### src/rpn_stack_evaluator.sv
// Postfix (RPN) evaluator over a 256-entry stack of signed Q16.16 values. Each
// input word is one token: push a number, or pop two entries and push
// second-from-top op top (add, subtract, multiply, divide), saturated. Errors
// (too few operands, full stack, divide by zero) are sticky and freeze the stack
// until the token marked last, which reports the bottom entry and the depth and
// then clears stack and error. Exactly one output word per token. Tokens are
// handled one at a time: a push, a no-op or an erroring token is quickest, then
// add and subtract, then multiply, and divide is slowest, set by the one-bit-per-
// cycle restoring divider plus the registered read of the stack memory. A token
// may be accepted while the previous output word still waits. The stack memory
// needs no clearing after reset; only held entries are ever read.
module rpn_stack_evaluator
  import rse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] number
  input  logic [OP_W-1:0]       s_axis_tuser,   // [2:0] op
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] result, [40:32] depth
  output logic [STATUS_W-1:0]   m_axis_tuser,   // [1:0] status
  output logic                  m_axis_tlast
);

  cmd_t                cmd;
  sts_t                sts;
  logic [NUM_W-1:0]    out_result;
  logic [DEPTH_W-1:0]  out_depth;

  rse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rse_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (s_axis_tuser),
    .in_num     (s_axis_tdata[NUM_W-1:0]),
    .in_last    (s_axis_tlast),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (m_axis_tuser),
    .out_result (out_result),
    .out_depth  (out_depth),
    .out_last   (m_axis_tlast)
  );

  // Output word packing
  assign m_axis_tdata = {{(OUT_DATA_W - NUM_W - DEPTH_W){1'b0}}, out_depth, out_result};

`ifndef SYNTH
  // One token at a time
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("token accepted while previous one in flight");

  // Push and write-back never share the memory write port
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push, cmd.wb}))
    else $error("two stack writes in one cycle");

  // Divider cannot report done right after a start
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !sts.div_done)
    else $error("divider done too early");

  // Reported depth stays within the stack
  a_depth: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[40:32] <= DEPTH_W'(STACK_DEPTH)))
    else $error("depth beyond stack size");
`endif

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rse_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_TOKENS   = 170;
  localparam int DRAIN_CYCLES   = 60;
  localparam int DIRECTED_ROWS  = 26;
  localparam int MAX_PRINTS     = 40;

  // Op codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_NOP_A = 3'd5;
  localparam logic [OP_W-1:0] OP_NOP_B = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    result;
    logic [DEPTH_W-1:0]  depth;
    logic                done;
  } result_word_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [NUM_W-1:0] number;
    logic             last;
    logic             known;
    result_word_t     want;
  } token_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [31:0] number
  logic [OP_W-1:0]       s_axis_tuser;   // [2:0] op
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [31:0] result, [40:32] depth
  logic [STATUS_W-1:0]   m_axis_tuser;   // [1:0] status
  logic                  m_axis_tlast;

  // Shadow of the evaluator state
  logic signed [NUM_W-1:0] shadow_stack [STACK_DEPTH];
  int                      shadow_count;
  logic [STATUS_W-1:0]     shadow_fault;

  result_word_t expected_words [$];
  int           mismatch_count;
  int           words_seen;
  int           tokens_sent;
  int           send_idle_pct;
  int           recv_stall_pct;
  logic         hold_req;
  logic         hold_active;

  // Directed tokens; a known row carries its expected word, the rest use the predictor
  token_row_t directed_rows [DIRECTED_ROWS] = '{
    // empty stack: too few operands, sticky until the last mark
    '{OP_ADD,   32'h0000_0000, 1'b0, 1'b1, '{ERR_FEW,  32'h0000_0000, 9'd0, 1'b0}},
    '{OP_PUSH,  32'h0000_0005, 1'b0, 1'b1, '{ERR_FEW,  32'h0000_0000, 9'd0, 1'b0}},
    '{OP_NOP_B, 32'hFFFF_FFFF, 1'b1, 1'b1, '{ERR_FEW,  32'h0000_0000, 9'd0, 1'b1}},
    // saturation at both ends
    '{OP_PUSH,  Q_MAX,         1'b0, 1'b1, '{ERR_NONE, Q_MAX,         9'd1, 1'b0}},
    '{OP_PUSH,  Q_MAX,         1'b0, 1'b1, '{ERR_NONE, Q_MAX,         9'd2, 1'b0}},
    '{OP_ADD,   32'h0000_0000, 1'b0, 1'b1, '{ERR_NONE, Q_MAX,         9'd1, 1'b0}},
    '{OP_PUSH,  Q_MIN,         1'b0, 1'b1, '{ERR_NONE, Q_MIN,         9'd2, 1'b0}},
    '{OP_SUB,   32'h0000_0000, 1'b0, 1'b1, '{ERR_NONE, Q_MAX,         9'd1, 1'b0}},
    '{OP_PUSH,  Q_MIN,         1'b0, 1'b1, '{ERR_NONE, Q_MIN,         9'd2, 1'b0}},
    '{OP_MUL,   32'h0000_0000, 1'b0, 1'b1, '{ERR_NONE, Q_MIN,         9'd1, 1'b0}},
    // divide by zero freezes the stack; last reports the bottom entry
    '{OP_PUSH,  32'h0000_0000, 1'b0, 1'b1, '{ERR_NONE, 32'h0000_0000, 9'd2, 1'b0}},
    '{OP_DIV,   32'h0000_0000, 1'b0, 1'b1, '{ERR_DIV0, 32'h0000_0000, 9'd2, 1'b0}},
    '{OP_NOP_A, 32'h1234_5678, 1'b1, 1'b1, '{ERR_DIV0, Q_MIN,         9'd2, 1'b1}},
    // single push closed at once
    '{OP_PUSH,  32'hFFFF_FFFF, 1'b1, 1'b1, '{ERR_NONE, 32'hFFFF_FFFF, 9'd1, 1'b1}},
    // ordinary arithmetic
    '{OP_PUSH,  32'h0003_0000, 1'b0, 1'b0, '0},
    '{OP_PUSH,  32'hFFFF_8000, 1'b0, 1'b0, '0},
    '{OP_MUL,   32'h0000_0000, 1'b0, 1'b0, '0},
    '{OP_PUSH,  32'h0002_0000, 1'b0, 1'b0, '0},
    '{OP_DIV,   32'h0000_0000, 1'b0, 1'b0, '0},
    '{OP_PUSH,  Q_MIN,         1'b0, 1'b0, '0},
    '{OP_PUSH,  32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{OP_DIV,   32'h0000_0000, 1'b0, 1'b0, '0},
    '{OP_SUB,   32'h0000_0000, 1'b1, 1'b0, '0},
    // multiply rounding toward minus infinity
    '{OP_PUSH,  32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{OP_PUSH,  32'h0000_0001, 1'b0, 1'b0, '0},
    '{OP_MUL,   32'h0000_0000, 1'b1, 1'b0, '0}
  };

  rpn_stack_evaluator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one token to the shadow state and returns the word it should produce
  function automatic result_word_t evaluate_token(input logic [OP_W-1:0] op,
                                                  input logic [NUM_W-1:0] number,
                                                  input logic last);
    result_word_t w;
    longint s;
    longint t;
    longint p;
    if (shadow_fault == ERR_NONE) begin
      if (op == OP_PUSH) begin
        if (shadow_count >= STACK_DEPTH) begin
          shadow_fault = ERR_FULL;
        end else begin
          shadow_stack[shadow_count] = number;
          shadow_count++;
        end
      end else if (op <= OP_DIV) begin
        if (shadow_count < 2) begin
          shadow_fault = ERR_FEW;
        end else begin
          t = shadow_stack[shadow_count-1];
          s = shadow_stack[shadow_count-2];
          if (op == OP_DIV && t == 0) begin
            shadow_fault = ERR_DIV0;
          end else begin
            case (op)
              OP_ADD:  p = s + t;
              OP_SUB:  p = s - t;
              OP_MUL:  p = (s * t) >>> 16;
              default: p = (s * 65536) / t;
            endcase
            if (p > 64'sd2147483647) begin
              p = 64'sd2147483647;
            end else if (p < -64'sd2147483648) begin
              p = -64'sd2147483648;
            end
            shadow_stack[shadow_count-2] = p[NUM_W-1:0];
            shadow_count--;
          end
        end
      end
    end
    w.status = shadow_fault;
    w.result = '0;
    if (shadow_count > 0) begin
      w.result = last ? shadow_stack[0] : shadow_stack[shadow_count-1];
    end
    w.depth = DEPTH_W'(shadow_count);
    w.done  = last;
    if (last) begin
      shadow_count = 0;
      shadow_fault = ERR_NONE;
    end
    return w;
  endfunction

  // Q16.16 operands biased toward zeros, extremes and small values
  function automatic logic [NUM_W-1:0] pick_number();
    logic [NUM_W-1:0] v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = Q_MAX;
      2:       v = Q_MIN;
      3, 4, 5: v = $urandom_range(32'h0010_0000) - 32'h0008_0000;
      6:       v = ($urandom_range(16) - 8) << 16;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic flag_mismatch(input string field, input logic [NUM_W-1:0] got,
                               input logic [NUM_W-1:0] want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("MISMATCH word %0d %s: got %h want %h", words_seen, field, got, want);
    end
    mismatch_count++;
  endtask

  // Offer one token and hold it until accepted; predict at the accepting edge
  task automatic offer_token(input logic [OP_W-1:0] op, input logic [NUM_W-1:0] number,
                             input logic last, input logic known,
                             input result_word_t want);
    result_word_t predicted;
    logic         counts;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= number;
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    counts    = (shadow_fault == ERR_NONE) || last;
    predicted = evaluate_token(op, number, last);
    expected_words.push_back(known ? want : predicted);
    if (counts) tokens_sent++;
  endtask

  // Well-formed expression: random operands and operators, last on the final token
  task automatic push_expression(input int operands);
    int              depth;
    int              left;
    logic [OP_W-1:0] op;
    logic            last;
    depth = 0;
    left  = operands;
    while (left > 0 || depth > 1) begin
      if (depth >= 2 && (left == 0 || $urandom_range(1) == 1)) begin
        case ($urandom_range(3))
          0:       op = OP_ADD;
          1:       op = OP_SUB;
          2:       op = OP_MUL;
          default: op = OP_DIV;
        endcase
        depth--;
      end else begin
        op = OP_PUSH;
        depth++;
        left--;
      end
      last = (left == 0 && depth == 1);
      offer_token(op, pick_number(), last, 1'b0, '0);
    end
  endtask

  // Short run of arbitrary tokens, unused op codes included
  task automatic noise_run();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      offer_token(OP_W'($urandom_range(7)), $urandom,
                  (i == n - 1) && ($urandom_range(1) == 1), 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, or a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      m_axis_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long hold-off, counted here
  initial begin
    hold_active = 1'b0;
    wait (hold_req);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  // Compare each output word with the oldest expectation
  always @(posedge clk) begin
    result_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        flag_mismatch("unexpected word", m_axis_tdata[NUM_W-1:0], '0);
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tuser !== want.status) begin
          flag_mismatch("status", NUM_W'(m_axis_tuser), NUM_W'(want.status));
        end
        if (m_axis_tdata[31:0] !== want.result) begin
          flag_mismatch("result", m_axis_tdata[31:0], want.result);
        end
        if (m_axis_tdata[40:32] !== want.depth) begin
          flag_mismatch("depth", NUM_W'(m_axis_tdata[40:32]), NUM_W'(want.depth));
        end
        if (m_axis_tlast !== want.done) begin
          flag_mismatch("last", NUM_W'(m_axis_tlast), NUM_W'(want.done));
        end
      end
      words_seen++;
    end
  end

  // Watchdog: ends the run after too long without any accepted token or output word
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Main sequence
  initial begin
    int idle_pcts  [4];
    int stall_pcts [4];
    int phase_start;
    int operands;
    idle_pcts      = '{0, 60, 0, 36};
    stall_pcts     = '{0, 0, 60, 36};
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_PUSH;
    s_axis_tlast   = 1'b0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    words_seen     = 0;
    tokens_sent    = 0;
    shadow_count   = 0;
    shadow_fault   = ERR_NONE;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_token(directed_rows[i].op, directed_rows[i].number, directed_rows[i].last,
                  directed_rows[i].known, directed_rows[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_pcts[ph];
      recv_stall_pct = stall_pcts[ph];
      if (ph == 0) begin
        // fill every entry, overflow once, then close the frozen stack
        for (int i = 0; i < STACK_DEPTH; i++) begin
          offer_token(OP_PUSH, pick_number(), 1'b0, 1'b0, '0);
        end
        offer_token(OP_PUSH, pick_number(), 1'b0, 1'b0, '0);
        offer_token(OP_ADD, $urandom, 1'b1, 1'b0, '0);
        // sender keeps offering while the receiver holds off
        hold_req = 1'b1;
      end
      phase_start = tokens_sent;
      while (tokens_sent - phase_start < PHASE_TOKENS) begin
        if ($urandom_range(4) == 0) begin
          noise_run();
        end else begin
          operands = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
          push_expression(operands);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
src/rse_pkg.sv
src/rse_divider.sv
src/rse_datapath.sv
src/rse_ctrl.sv
src/rpn_stack_evaluator.sv
bench/tb_top.sv
